// File: rtl/lq_pkg.sv
// Package for the linear Q-learning agent: defaults, action codes, saturation helper.
package lq_pkg;

   localparam int NumChoicesDefault  = 3;
   localparam int NumFeaturesDefault = 3;

   localparam logic [15:0] LearningRateReset = 16'd131;
   localparam logic [15:0] DiscountReset     = 16'd64881;
   localparam logic [16:0] ExploreDecReset   = 17'd131;
   localparam logic [16:0] ExploreRateReset  = 17'd65536;
   localparam logic [16:0] FeatureOne        = 17'd65536;

   localparam int MulAWidth = 32;
   localparam int MulBWidth = 17;
   localparam int MulPWidth = MulAWidth + MulBWidth + 1;

   typedef enum logic [1:0] {
      ACT_GREEDY  = 2'd0,
      ACT_EXPLORE = 2'd1,
      ACT_UPDATE  = 2'd2,
      ACT_END     = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      CSR_LEARNING_RATE = 2'd0,
      CSR_DISCOUNT      = 2'd1,
      CSR_EXPLORE_DEC   = 2'd2,
      CSR_UNUSED        = 2'd3
   } csr_index_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > 64'sh0000_0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (x < -64'sh0000_0000_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

// File: rtl/lq_mul.sv
// Shared signed-by-unsigned multiplier with registered product.
module lq_mul
   import lq_pkg::*;
(
   input  logic                               clock,
   input  logic signed [MulAWidth-1:0]        a,
   input  logic        [MulBWidth-1:0]        b,
   output logic signed [MulPWidth-1:0]        prod_ff
);

   logic signed [MulPWidth-1:0] prod_in;

   assign prod_in = MulPWidth'(a) * $signed({1'b0, b});

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// File: rtl/linear_q_learning_agent.sv
// Top level of the linear Q-learning agent: sequencer, weight table, state.
//
// Usage: drive the req_ ports and pulse start while busy is low; the
// transaction is taken at that edge. Exactly one result follows, shown on
// the rsp_ ports for one cycle with rsp_valid high; the receiver cannot
// stall and must take it then.
// Sequencing, one multiply/accumulate pair per feature on a single shared
// multiplier (F = NUM_INPUT_FEATURES, C = NUM_CHOICES):
//   greedy choose:     F pairs for each of the C choices
//   exploring choose:  F pairs on the random pick, else as greedy
//   update:            as greedy unless finished; TD error; F weight updates
//   end of match:      no multiplies, busy stays low
// A new transaction may start in the cycle the result is shown.
// Registers are written through csr_we/csr_index/csr_data; the user must
// write them only while idle (not enforced by the block); index 3 is ignored.
// Reset (synchronous) clears the weights and saved state, sets the
// exploration rate to 1.0 and the registers to their defaults.
module linear_q_learning_agent
   import lq_pkg::*;
#(
   parameter int NUM_CHOICES        = NumChoicesDefault,
   parameter int NUM_INPUT_FEATURES = NumFeaturesDefault
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_action,
   input  logic [15:0]        req_food_closeness,
   input  logic [15:0]        req_ghost_probability,
   input  logic               req_finished,
   input  logic signed [15:0] req_reward,
   input  logic [15:0]        req_explore_draw,
   input  logic [1:0]         req_explore_pick,
   output logic               rsp_valid,
   output logic [1:0]         rsp_chosen_behavior,
   output logic signed [31:0] rsp_q_value,
   output logic signed [31:0] rsp_td_error,
   output logic               rsp_explored,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [16:0]        csr_data
);

   localparam int CW  = $clog2(NUM_CHOICES);
   localparam int FW  = $clog2(NUM_INPUT_FEATURES);
   localparam int NW  = NUM_CHOICES * NUM_INPUT_FEATURES;
   localparam int WAW = $clog2(NW);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b00_0000_0001,
      S_QMUL  = 10'b00_0000_0010,
      S_QACC  = 10'b00_0000_0100,
      S_QEND  = 10'b00_0000_1000,
      S_TGMUL = 10'b00_0001_0000,
      S_TERR  = 10'b00_0010_0000,
      S_TAMUL = 10'b00_0100_0000,
      S_TSTEP = 10'b00_1000_0000,
      S_UMUL  = 10'b01_0000_0000,
      S_UACC  = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [15:0] alpha_ff, alpha_in;
   logic [15:0] gamma_ff, gamma_in;
   logic [16:0] edec_ff, edec_in;
   logic [16:0] erate_ff, erate_in;

   logic signed [31:0] w_ff [NW];
   logic [15:0]        sfood_ff, sfood_in;
   logic [15:0]        sghost_ff, sghost_in;
   logic [CW-1:0]      sbeh_ff, sbeh_in;
   logic signed [31:0] sq_ff, sq_in;

   action_type         act_ff, act_in;
   logic [15:0]        food_ff, food_in;
   logic [15:0]        ghost_ff, ghost_in;
   logic signed [15:0] reward_ff, reward_in;
   logic               single_ff, single_in;
   logic [CW-1:0]      b_ff, b_in;
   logic [FW-1:0]      i_ff, i_in;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [31:0] bestq_ff, bestq_in;
   logic [CW-1:0]      bestb_ff, bestb_in;
   logic signed [31:0] td_ff, td_in;
   logic signed [31:0] step_ff, step_in;

   logic               rv_ff, rv_in;
   logic [1:0]         rbeh_ff, rbeh_in;
   logic signed [31:0] rq_ff, rq_in;
   logic signed [31:0] rtd_ff, rtd_in;
   logic               rexp_ff, rexp_in;

   logic signed [MulAWidth-1:0] mul_a;
   logic [MulBWidth-1:0]        mul_b;
   logic signed [MulPWidth-1:0] prod;

   logic [WAW-1:0]     qaddr, uaddr;
   logic               wr_en;
   logic signed [31:0] wr_data;
   logic signed [63:0] prod_sh;
   logic signed [31:0] q_now;
   logic               take;
   logic [2:0]         pick_ext;
   logic [CW-1:0]      pick_mod;
   logic [CW+1:0]      beh_ext;
   logic [CW+1:0]      sbeh_ext;
   logic [17:0]        erate_diff;

   lq_mul u_mul (
      .clock   (clock),
      .a       (mul_a),
      .b       (mul_b),
      .prod_ff (prod)
   );

   function automatic logic [16:0] feat(input logic [FW-1:0] idx,
                                        input logic [15:0] f1,
                                        input logic [15:0] f2);
      logic [16:0] r;
      if (32'(idx) == 0) begin
         r = FeatureOne;
      end else if (32'(idx) == 1) begin
         r = {1'b0, f1};
      end else if (32'(idx) == 2) begin
         r = {1'b0, f2};
      end else begin
         r = '0;
      end
      return r;
   endfunction

   assign qaddr   = WAW'(int'(b_ff) * NUM_INPUT_FEATURES + int'(i_ff));
   assign uaddr   = WAW'(int'(sbeh_ff) * NUM_INPUT_FEATURES + int'(i_ff));
   assign prod_sh = 64'(prod >>> 16);
   assign q_now   = sat32(acc_ff >>> 16);
   assign take    = single_ff || (b_ff == '0) || (q_now > bestq_ff);
   assign pick_ext = {1'b0, req_explore_pick};
   assign pick_mod = (32'(pick_ext) >= NUM_CHOICES) ?
                     CW'(32'(pick_ext) - NUM_CHOICES) : CW'(pick_ext);
   assign beh_ext  = {2'b00, (take ? b_ff : bestb_ff)};
   assign sbeh_ext = {2'b00, sbeh_ff};
   assign erate_diff = {1'b0, erate_ff} - {1'b0, edec_ff};
   assign wr_data  = sat32(64'(w_ff[uaddr]) + prod_sh);

   assign busy                = (state_ff != S_IDLE);
   assign rsp_valid           = rv_ff;
   assign rsp_chosen_behavior = rbeh_ff;
   assign rsp_q_value         = rq_ff;
   assign rsp_td_error        = rtd_ff;
   assign rsp_explored        = rexp_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_QMUL: begin
            mul_a = w_ff[qaddr];
            mul_b = feat(i_ff, food_ff, ghost_ff);
         end
         S_TGMUL: begin
            mul_a = bestq_ff;
            mul_b = {1'b0, gamma_ff};
         end
         S_TAMUL: begin
            mul_a = td_ff;
            mul_b = {1'b0, alpha_ff};
         end
         S_UMUL: begin
            mul_a = step_ff;
            mul_b = feat(i_ff, sfood_ff, sghost_ff);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      alpha_in  = alpha_ff;
      gamma_in  = gamma_ff;
      edec_in   = edec_ff;
      erate_in  = erate_ff;
      sfood_in  = sfood_ff;
      sghost_in = sghost_ff;
      sbeh_in   = sbeh_ff;
      sq_in     = sq_ff;
      act_in    = act_ff;
      food_in   = food_ff;
      ghost_in  = ghost_ff;
      reward_in = reward_ff;
      single_in = single_ff;
      b_in      = b_ff;
      i_in      = i_ff;
      acc_in    = acc_ff;
      bestq_in  = bestq_ff;
      bestb_in  = bestb_ff;
      td_in     = td_ff;
      step_in   = step_ff;
      rv_in     = 1'b0;
      rbeh_in   = rbeh_ff;
      rq_in     = rq_ff;
      rtd_in    = rtd_ff;
      rexp_in   = rexp_ff;
      wr_en     = 1'b0;

      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_LEARNING_RATE: alpha_in = csr_data[15:0];
            CSR_DISCOUNT:      gamma_in = csr_data[15:0];
            CSR_EXPLORE_DEC:   edec_in  = csr_data;
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               act_in    = action_type'(req_action);
               food_in   = req_food_closeness;
               ghost_in  = req_ghost_probability;
               reward_in = req_reward;
               single_in = 1'b0;
               b_in      = '0;
               i_in      = '0;
               acc_in    = '0;
               case (action_type'(req_action))
                  ACT_GREEDY: state_in = S_QMUL;
                  ACT_EXPLORE: begin
                     state_in = S_QMUL;
                     if ({1'b0, req_explore_draw} < erate_ff) begin
                        single_in = 1'b1;
                        b_in      = pick_mod;
                     end
                  end
                  ACT_UPDATE: begin
                     if (req_finished) begin
                        bestq_in = '0;
                        state_in = S_TGMUL;
                     end else begin
                        state_in = S_QMUL;
                     end
                  end
                  default: begin
                     erate_in = erate_diff[17] ? '0 : erate_diff[16:0];
                     rv_in    = 1'b1;
                     rbeh_in  = sbeh_ext[1:0];
                     rq_in    = '0;
                     rtd_in   = '0;
                     rexp_in  = 1'b0;
                  end
               endcase
            end
         end
         S_QMUL: state_in = S_QACC;
         S_QACC: begin
            acc_in = acc_ff + 64'(prod);
            if (32'(i_ff) == NUM_INPUT_FEATURES - 1) begin
               i_in     = '0;
               state_in = S_QEND;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_QMUL;
            end
         end
         S_QEND: begin
            acc_in = '0;
            if (take) begin
               bestq_in = q_now;
               bestb_in = b_ff;
            end
            if (!single_ff && (32'(b_ff) != NUM_CHOICES - 1)) begin
               b_in     = b_ff + 1'b1;
               state_in = S_QMUL;
            end else if (act_ff == ACT_UPDATE) begin
               state_in = S_TGMUL;
            end else begin
               sbeh_in   = take ? b_ff : bestb_ff;
               sq_in     = take ? q_now : bestq_ff;
               sfood_in  = food_ff;
               sghost_in = ghost_ff;
               rv_in     = 1'b1;
               rbeh_in   = beh_ext[1:0];
               rq_in     = take ? q_now : bestq_ff;
               rtd_in    = '0;
               rexp_in   = single_ff;
               state_in  = S_IDLE;
            end
         end
         S_TGMUL: state_in = S_TERR;
         S_TERR: begin
            td_in    = sat32({{32{reward_ff[15]}}, reward_ff, 16'h0000} + prod_sh
                             - 64'(sq_ff));
            state_in = S_TAMUL;
         end
         S_TAMUL: state_in = S_TSTEP;
         S_TSTEP: begin
            step_in  = prod_sh[31:0];
            i_in     = '0;
            state_in = S_UMUL;
         end
         S_UMUL: state_in = S_UACC;
         S_UACC: begin
            wr_en = 1'b1;
            if (32'(i_ff) == NUM_INPUT_FEATURES - 1) begin
               i_in     = '0;
               rv_in    = 1'b1;
               rbeh_in  = sbeh_ext[1:0];
               rq_in    = bestq_ff;
               rtd_in   = td_ff;
               rexp_in  = 1'b0;
               state_in = S_IDLE;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_UMUL;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         alpha_ff  <= LearningRateReset;
         gamma_ff  <= DiscountReset;
         edec_ff   <= ExploreDecReset;
         erate_ff  <= ExploreRateReset;
         sfood_ff  <= '0;
         sghost_ff <= '0;
         sbeh_ff   <= '0;
         sq_ff     <= '0;
         rv_ff     <= 1'b0;
         for (int k = 0; k < NW; k++) begin
            w_ff[k] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         alpha_ff  <= alpha_in;
         gamma_ff  <= gamma_in;
         edec_ff   <= edec_in;
         erate_ff  <= erate_in;
         sfood_ff  <= sfood_in;
         sghost_ff <= sghost_in;
         sbeh_ff   <= sbeh_in;
         sq_ff     <= sq_in;
         rv_ff     <= rv_in;
         if (wr_en) begin
            w_ff[uaddr] <= wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      food_ff   <= food_in;
      ghost_ff  <= ghost_in;
      reward_ff <= reward_in;
      single_ff <= single_in;
      b_ff      <= b_in;
      i_ff      <= i_in;
      acc_ff    <= acc_in;
      bestq_ff  <= bestq_in;
      bestb_ff  <= bestb_in;
      td_ff     <= td_in;
      step_ff   <= step_in;
      rbeh_ff   <= rbeh_in;
      rq_ff     <= rq_in;
      rtd_ff    <= rtd_in;
      rexp_ff   <= rexp_in;
   end

endmodule
